// ===== hdl/gbr_pkg.sv =====
// Shared types, constants and the 5x7 glyph table for the glyph blitter.
// Depends on nothing; every other file of the block uses it.
package gbr_pkg;

  localparam int VIEW_WIDTH_DEF  = 64;
  localparam int VIEW_HEIGHT_DEF = 128;

  localparam int GLYPH_ROWS = 7;
  localparam int GLYPH_COLS = 5;

  localparam logic [2:0] LAST_ROW = 3'(GLYPH_ROWS - 1);
  localparam logic [2:0] LAST_COL = 3'(GLYPH_COLS - 1);
  localparam logic [5:0] PANEL_LAST_X = 6'd63;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_E     = 8'h45;
  localparam logic [7:0] CHAR_L     = 8'h4C;
  localparam logic [7:0] CHAR_M     = 8'h4D;
  localparam logic [7:0] CHAR_O     = 8'h4F;
  localparam logic [7:0] CHAR_P     = 8'h50;
  localparam logic [7:0] CHAR_R     = 8'h52;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_U     = 8'h55;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } gbr_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic flush;
  } gbr_cmd_t;

  typedef struct packed {
    logic scan_end;
  } gbr_stat_t;

  typedef logic [4:0] font_rows_t [GLYPH_ROWS];

  localparam font_rows_t FONT_A = '{5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
  localparam font_rows_t FONT_E = '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
  localparam font_rows_t FONT_L = '{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
  localparam font_rows_t FONT_M = '{5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
  localparam font_rows_t FONT_O = '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
  localparam font_rows_t FONT_P = '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
  localparam font_rows_t FONT_R = '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
  localparam font_rows_t FONT_T = '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
  localparam font_rows_t FONT_U = '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};

  // Row pattern of a character; bit 4 is the leftmost column.
  function automatic logic [4:0] glyph_bits(input logic [7:0] code, input logic [2:0] row);
    logic [4:0] bits;
    if (row > LAST_ROW) begin
      bits = 5'h00;
    end else begin
      case (code)
        CHAR_A:     bits = FONT_A[row];
        CHAR_E:     bits = FONT_E[row];
        CHAR_L:     bits = FONT_L[row];
        CHAR_M:     bits = FONT_M[row];
        CHAR_O:     bits = FONT_O[row];
        CHAR_P:     bits = FONT_P[row];
        CHAR_R:     bits = FONT_R[row];
        CHAR_T:     bits = FONT_T[row];
        CHAR_U:     bits = FONT_U[row];
        CHAR_SPACE: bits = 5'h00;
        default:    bits = 5'h1F;
      endcase
    end
    return bits;
  endfunction

endpackage

// ===== hdl/glyph_blitter_5x7_rotated_panel.sv =====
// Top level of the 5x7 glyph blitter for a rotated panel.
// Depends on gbr_pkg, gbr_ctrl and gbr_dp.
//
// A beat is accepted when start is high while busy is low. The block then
// scans the glyph one pixel position per cycle, 7 rows by 5 columns, and a
// final flush step releases the held last write. Busy stays high through the
// scan and the flush, so a new character is taken only after the last
// one is done and the block is idle again. Each lit pixel in view
// gives one write beat on the out_ ports, marked by out_strobe for one cycle;
// the receiver cannot stall and must take every beat. The last beat of a
// character carries out_last_write; a character with nothing lit in view
// gives no beats. Write beats trail the scan by one lit pixel.
module glyph_blitter_5x7_rotated_panel #(
  parameter int VIEW_WIDTH  = gbr_pkg::VIEW_WIDTH_DEF,
  parameter int VIEW_HEIGHT = gbr_pkg::VIEW_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [5:0]  in_origin_x,
  input  logic [6:0]  in_origin_y,
  input  logic [7:0]  in_char_code,
  input  logic [7:0]  in_pixel_color,
  output logic        out_strobe,
  output logic [12:0] out_write_addr,
  output logic [7:0]  out_write_data,
  output logic        out_last_write
);

  gbr_pkg::gbr_cmd_t  cmd;
  gbr_pkg::gbr_stat_t stat;

  gbr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  gbr_dp #(
    .VIEW_WIDTH  (VIEW_WIDTH),
    .VIEW_HEIGHT (VIEW_HEIGHT)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_origin_x    (in_origin_x),
    .in_origin_y    (in_origin_y),
    .in_char_code   (in_char_code),
    .in_pixel_color (in_pixel_color),
    .out_strobe     (out_strobe),
    .out_write_addr (out_write_addr),
    .out_write_data (out_write_data),
    .out_last_write (out_last_write)
  );

endmodule

// ===== hdl/gbr_ctrl.sv =====
// Controller state machine of the glyph blitter: load, scan and flush sequencing.
// Depends on gbr_pkg.
module gbr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  gbr_pkg::gbr_stat_t stat,
  output gbr_pkg::gbr_cmd_t  cmd
);

  gbr_pkg::gbr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gbr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      gbr_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = gbr_pkg::ST_SCAN;
        end
      end
      gbr_pkg::ST_SCAN: begin
        cmd.step = 1'b1;
        if (stat.scan_end) begin
          state_nxt = gbr_pkg::ST_FLUSH;
        end
      end
      gbr_pkg::ST_FLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = gbr_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = gbr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/gbr_dp.sv =====
// Datapath of the glyph blitter: scan counters, glyph lookup, view clipping,
// one-deep hold of the latest write and the output registers. Depends on gbr_pkg.
module gbr_dp #(
  parameter int VIEW_WIDTH  = gbr_pkg::VIEW_WIDTH_DEF,
  parameter int VIEW_HEIGHT = gbr_pkg::VIEW_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gbr_pkg::gbr_cmd_t  cmd,
  output gbr_pkg::gbr_stat_t stat,
  input  logic [5:0]         in_origin_x,
  input  logic [6:0]         in_origin_y,
  input  logic [7:0]         in_char_code,
  input  logic [7:0]         in_pixel_color,
  output logic               out_strobe,
  output logic [12:0]        out_write_addr,
  output logic [7:0]         out_write_data,
  output logic               out_last_write
);

  logic [5:0]  ox_r;
  logic [6:0]  oy_r;
  logic [7:0]  code_r;
  logic [7:0]  color_r;
  logic [2:0]  row_r, row_nxt;
  logic [2:0]  col_r, col_nxt;
  logic        pend_valid_r;
  logic [12:0] pend_addr_r;
  logic        out_strobe_r;
  logic [12:0] out_addr_r;
  logic [7:0]  out_data_r;
  logic        out_last_r;

  logic [4:0]  bits;
  logic        lit;
  logic [6:0]  x;
  logic [7:0]  y;
  logic        hit;
  logic [12:0] addr;

  always_comb begin
    bits = gbr_pkg::glyph_bits(code_r, row_r);
    lit  = bits[3'(gbr_pkg::LAST_COL - col_r)];
    x    = {1'b0, ox_r} + {4'd0, col_r};
    y    = {1'b0, oy_r} + {5'd0, row_r};
    hit  = lit && (x < 7'(VIEW_WIDTH)) && (y < 8'(VIEW_HEIGHT));
    addr = {gbr_pkg::PANEL_LAST_X - x[5:0], y[6:0]};
    stat.scan_end = (row_r == gbr_pkg::LAST_ROW) && (col_r == gbr_pkg::LAST_COL);
    row_nxt = row_r;
    col_nxt = col_r + 3'd1;
    if (col_r == gbr_pkg::LAST_COL) begin
      col_nxt = 3'd0;
      row_nxt = row_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ox_r    <= in_origin_x;
      oy_r    <= in_origin_y;
      code_r  <= in_char_code;
      color_r <= in_pixel_color;
    end
    if (cmd.step && hit) begin
      pend_addr_r <= addr;
    end
    out_data_r <= color_r;
    if (cmd.flush) begin
      out_addr_r <= pend_addr_r;
      out_last_r <= 1'b1;
    end else begin
      out_addr_r <= pend_addr_r;
      out_last_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r        <= 3'd0;
      col_r        <= 3'd0;
      pend_valid_r <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      if (cmd.load) begin
        row_r        <= 3'd0;
        col_r        <= 3'd0;
        pend_valid_r <= 1'b0;
      end else if (cmd.step) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
        if (hit) begin
          out_strobe_r <= pend_valid_r;
          pend_valid_r <= 1'b1;
        end
      end else if (cmd.flush) begin
        out_strobe_r <= pend_valid_r;
        pend_valid_r <= 1'b0;
      end
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_write_addr = out_addr_r;
  assign out_write_data = out_data_r;
  assign out_last_write = out_last_r;

  a_last_clears_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_last_r) |-> !pend_valid_r)
    else $error("final write left a pending write behind");

  a_load_resets_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (row_r == 3'd0 && col_r == 3'd0 && !pend_valid_r))
    else $error("scan did not restart on load");

  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(cmd.step || cmd.flush))
    else $error("write strobe without a scan or flush step");

  a_no_double_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.load, cmd.step, cmd.flush}) <= 1)
    else $error("more than one datapath command at once");

endmodule
